// File: hdl/sitoa_pkg.sv
// sitoa_pkg: shared types and character constants for the signed integer
// to decimal text block; used by the digit cell, the core and its checker.
// no dependencies.
package sitoa_pkg;

   // one bcd digit held by a cell
   localparam int DIGIT_BITS = 4;
   typedef logic [DIGIT_BITS-1:0] digit_type;

   // ascii codes that the block emits
   localparam logic [7:0] CH_ZERO  = 8'd48;
   localparam logic [7:0] CH_NINE  = 8'd57;
   localparam logic [7:0] CH_MINUS = 8'd45;

   // control for the whole row of digit cells
   typedef struct packed {
      logic clear;   // zero the digit
      logic dabble;  // add-3 adjust and shift one binary bit in
      logic shift;   // take the digit of the lower neighbor
   } cell_ctrl_type;

endpackage

// File: hdl/signed_int_to_decimal_ascii_core.sv
// signed_int_to_decimal_ascii_core: top level, converts a signed integer to
// decimal ascii text; depends on sitoa_pkg and sitoa_digit_cell.
//
// usage
//   input: drive req_value and raise start; the item is taken at a rising
//   edge where start is high and busy is low. busy stays high until the
//   last character has been registered.
//   output: one character per cycle on rsp_char_code with rsp_strobe high
//   for exactly that cycle; rsp_last marks the final character. a minus
//   sign comes first for a negative value, then the digits with no leading
//   zeros (zero gives a single '0').
//   timing: double dabble through the row of digit cells (one magnitude
//   bit per cycle), then leading zeros are shifted out, then the digits
//   are emitted; DIGITS is the row length (10 at 32 bits). the block takes
//   no new item until the last character of the current one has been
//   registered. a minus sign directly precedes the first digit.
//   reset: synchronous, clears the sequencer and the strobe; an item in
//   progress is dropped. the receiver cannot stall, results are not held.
module signed_int_to_decimal_ascii_core #(
   parameter int VALUE_BITS = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic signed [VALUE_BITS-1:0] req_value,
   output logic                         rsp_strobe,
   output logic [7:0]                   rsp_char_code,
   output logic                         rsp_last
);
   import sitoa_pkg::*;

   // decimal digits needed for VALUE_BITS bits: floor(bits*log10(2))+1
   localparam int DIGITS = ((VALUE_BITS * 1233) >> 12) + 1;
   localparam int LW     = $clog2(DIGITS + 1);
   localparam int BW     = $clog2(VALUE_BITS);

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_CONV = 4'b0010,
      S_TRIM = 4'b0100,
      S_EMIT = 4'b1000
   } state_type;

   state_type             state_ff, state_in;
   logic [VALUE_BITS-1:0] mag_ff, mag_in;
   logic                  neg_ff, neg_in;
   logic [BW-1:0]         bit_ff, bit_in;
   logic [LW-1:0]         left_ff, left_in;
   logic                  strobe_ff, strobe_in;
   logic [7:0]            char_ff, char_in;
   logic                  last_ff, last_in;

   logic [VALUE_BITS-1:0] raw_w;
   logic [VALUE_BITS-1:0] req_mag_w;
   logic                  accept_w;
   logic                  top_zero_w;
   logic                  trim_go_w;
   cell_ctrl_type         cell_ctrl_w;

   digit_type             digit_w [DIGITS];
   logic                  carry_w [DIGITS];

   // magnitude as unsigned, exact for the most negative value
   assign raw_w     = req_value;
   assign req_mag_w = raw_w[VALUE_BITS-1] ? (~raw_w + 1'b1) : raw_w;

   assign busy       = (state_ff != S_IDLE);
   assign accept_w   = start && (state_ff == S_IDLE);
   assign top_zero_w = (digit_w[DIGITS-1] == '0);
   assign trim_go_w  = top_zero_w && (left_ff > LW'(1));

   // row control
   assign cell_ctrl_w.clear  = accept_w;
   assign cell_ctrl_w.dabble = (state_ff == S_CONV);
   assign cell_ctrl_w.shift  = ((state_ff == S_TRIM) && trim_go_w) || (state_ff == S_EMIT);

   // row of digit cells, lowest digit at index 0
   assign carry_w[0] = mag_ff[VALUE_BITS-1];
   for (genvar i = 0; i < DIGITS; i++) begin : g_cell
      if (i < DIGITS - 1) begin : g_mid
         sitoa_digit_cell u_cell (
            .clock     (clock),
            .ctrl      (cell_ctrl_w),
            .carry_in  (carry_w[i]),
            .digit_in  ((i == 0) ? digit_type'(0) : digit_w[(i == 0) ? 0 : i-1]),
            .digit_out (digit_w[i]),
            .carry_out (carry_w[i+1])
         );
      end else begin : g_top
         sitoa_digit_cell u_cell (
            .clock     (clock),
            .ctrl      (cell_ctrl_w),
            .carry_in  (carry_w[i]),
            .digit_in  ((i == 0) ? digit_type'(0) : digit_w[(i == 0) ? 0 : i-1]),
            .digit_out (digit_w[i]),
            .carry_out ()
         );
      end
   end

   // sequencer
   always_comb begin
      state_in  = state_ff;
      mag_in    = mag_ff;
      neg_in    = neg_ff;
      bit_in    = bit_ff;
      left_in   = left_ff;
      strobe_in = 1'b0;
      char_in   = char_ff;
      last_in   = last_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               mag_in   = req_mag_w;
               neg_in   = raw_w[VALUE_BITS-1];
               bit_in   = BW'(VALUE_BITS - 1);
               state_in = S_CONV;
            end
         end
         S_CONV: begin
            mag_in = {mag_ff[VALUE_BITS-2:0], 1'b0};
            bit_in = bit_ff - BW'(1);
            if (bit_ff == '0) begin
               left_in  = LW'(DIGITS);
               state_in = S_TRIM;
            end
         end
         S_TRIM: begin
            // drop leading zeros, keep at least one digit
            if (trim_go_w) begin
               left_in = left_ff - LW'(1);
            end else begin
               if (neg_ff) begin
                  strobe_in = 1'b1;
                  char_in   = CH_MINUS;
                  last_in   = 1'b0;
               end
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            strobe_in = 1'b1;
            char_in   = CH_ZERO + {4'd0, digit_w[DIGITS-1]};
            last_in   = (left_ff == LW'(1));
            left_in   = left_ff - LW'(1);
            if (left_ff == LW'(1)) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      mag_ff  <= mag_in;
      neg_ff  <= neg_in;
      bit_ff  <= bit_in;
      left_ff <= left_in;
      char_ff <= char_in;
      last_ff <= last_in;
   end

   assign rsp_strobe    = strobe_ff;
   assign rsp_char_code = char_ff;
   assign rsp_last      = last_ff;

endmodule

// File: hdl/sitoa_digit_cell.sv
// sitoa_digit_cell: one bcd digit of the double-dabble row, also a stage
// of the digit shift line used to emit the text; depends on sitoa_pkg.
module sitoa_digit_cell (
   input  logic                      clock,
   input  sitoa_pkg::cell_ctrl_type  ctrl,
   input  logic                      carry_in,
   input  sitoa_pkg::digit_type      digit_in,
   output sitoa_pkg::digit_type      digit_out,
   output logic                      carry_out
);
   import sitoa_pkg::*;

   digit_type digit_ff;
   digit_type digit_in_w;
   digit_type adj_w;

   // add 3 when the digit would overflow past 9 on the next doubling
   assign adj_w     = (digit_ff >= digit_type'(5)) ? digit_ff + digit_type'(3) : digit_ff;
   assign carry_out = adj_w[DIGIT_BITS-1];
   assign digit_out = digit_ff;

   // next digit
   always_comb begin
      if (ctrl.clear) begin
         digit_in_w = '0;
      end else if (ctrl.dabble) begin
         digit_in_w = {adj_w[DIGIT_BITS-2:0], carry_in};
      end else if (ctrl.shift) begin
         digit_in_w = digit_in;
      end else begin
         digit_in_w = digit_ff;
      end
   end

   always_ff @(posedge clock) begin
      digit_ff <= digit_in_w;
   end

endmodule

// File: hdl/sitoa_checker.sv
// sitoa_checker: port-level assertions for signed_int_to_decimal_ascii_core
// and the bind that attaches them; depends on sitoa_pkg.
module sitoa_checker (
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic       rsp_strobe,
   input logic [7:0] rsp_char_code,
   input logic       rsp_last
);
   import sitoa_pkg::*;

   // an accepted item keeps the block busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted item did not raise busy");

   // characters of one item come in consecutive cycles
   a_contiguous: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_last |=> rsp_strobe)
      else $error("gap inside the text of an item");

   // more characters pending means still busy, final one means idle
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (busy == !rsp_last))
      else $error("busy does not match the last flag");

   // only a sign or a digit is emitted
   a_char_code: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_char_code == CH_MINUS) ||
                     ((rsp_char_code >= CH_ZERO) && (rsp_char_code <= CH_NINE)))
      else $error("character code out of range");

   // the minus sign is never the final character
   a_minus_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp_char_code == CH_MINUS) |-> !rsp_last)
      else $error("minus sign flagged as last");

endmodule

bind signed_int_to_decimal_ascii_core sitoa_checker u_sitoa_checker (.*);
